// ===== rtl/battery_soc_estimator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the battery charge estimator
// Shared property shorthands; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BATTERY_SOC_ESTIMATOR_UNIT_MACROS_SVH
`define BATTERY_SOC_ESTIMATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define BSE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bse assertion failed");

// Next-cycle implication.
`define BSE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bse assertion failed");

`endif

// ===== rtl/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Types and constants shared by the charge estimator modules.
// ----------------------------------------------------------------------------
package bse_pkg;

	localparam int MODE_W     = 2;
	localparam int SAMPLE_W   = 12;
	localparam int IDX_W      = 4;
	localparam int VOLT_W     = 13;
	localparam int CHG_W      = 14;
	localparam int GAIN_W     = 16;
	localparam int OFFS_W     = 11;
	localparam int ALPHA_W    = 9;
	localparam int TSIZE_W    = 5;
	localparam int QUO_W      = 14;
	localparam int GAIN_FRAC  = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SEED   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;

	localparam logic [CHG_W-1:0]   FULL_CHARGE = 14'd10000;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE_GAIN  = 3'd0,
		CFG_OFFSET      = 3'd1,
		CFG_MIN_VALID   = 3'd2,
		CFG_MAX_VALID   = 3'd3,
		CFG_EMA_ALPHA   = 3'd4,
		CFG_TABLE_SIZE  = 3'd5,
		CFG_FLOOR_VOLT  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]        scale_gain;
		logic signed [OFFS_W-1:0] offset_mv;
		logic [VOLT_W-1:0]        min_valid_mv;
		logic [VOLT_W-1:0]        max_valid_mv;
		logic [ALPHA_W-1:0]       avg_weight;
		logic [TSIZE_W-1:0]       table_size;
		logic [VOLT_W-1:0]        floor_voltage_mv;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LOAD,
		OP_MUL_GAIN,
		OP_CORRECT,
		OP_LK_INIT_FLOOR,
		OP_LK_INIT_FILT,
		OP_LK_FIRST,
		OP_LK_LAST,
		OP_LK_MID,
		OP_LK_MIDCHK,
		OP_IP_MUL,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_IP_FIN,
		OP_SEED,
		OP_EMA_MUL,
		OP_EMA_ADD,
		OP_RM_SETUP,
		OP_RM_MUL,
		OP_RM_FIN
	} dp_op_t;

	typedef struct packed {
		logic   capture;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              le_first;
		logic              ge_last;
		logic              span_gt1;
	} dp_sts_t;

endpackage

// ===== rtl/bse_req_if.sv =====
// ----------------------------------------------------------------------------
// bse_req_if
// Input item channel: valid/ready with the item fields.
// ----------------------------------------------------------------------------
interface bse_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [11:0] sample_mv;
	logic [3:0]  entry_index;
	logic [12:0] entry_voltage_mv;
	logic [13:0] entry_charge;

	modport source (output valid, mode, sample_mv, entry_index, entry_voltage_mv,
		entry_charge, input ready);
	modport sink (input valid, mode, sample_mv, entry_index, entry_voltage_mv,
		entry_charge, output ready);
endinterface

// ===== rtl/bse_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bse_rsp_if
// Result channel: valid/ready with the result fields.
// ----------------------------------------------------------------------------
interface bse_rsp_if;
	logic        valid;
	logic        ready;
	logic [12:0] filtered_mv;
	logic [13:0] usable_charge;
	logic        sample_rejected;

	modport source (output valid, filtered_mv, usable_charge, sample_rejected,
		input ready);
	modport sink (input valid, filtered_mv, usable_charge, sample_rejected,
		output ready);
endinterface

// ===== rtl/battery_soc_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// battery_soc_estimator_unit
// Battery charge estimator: corrected, filtered voltage to usable charge.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transfer when        Payload
//  req      in         req.valid&req.ready  mode, sample, table entry
//  rsp      out        rsp.valid&rsp.ready  filtered_mv, usable_charge, rejected
//  cfg      in         cfg_we               cfg_index, cfg_data
//
//  One item at a time. A table load or the unused mode runs the gain and load
//  steps. An update runs correction, the filter, a lookup and the remap; a seed
//  runs correction, two lookups and the remap. A lookup stops at a table end or
//  else runs a binary search and an interpolation, using the one-port table
//  memory and the 14-step restoring divider shared by interpolation and remap.
//  Reset is asynchronous and needs no clearing pass; a result holds stable
//  while rsp.ready is low and no new item is taken until it transfers.
// ----------------------------------------------------------------------------
module battery_soc_estimator_unit #(
	parameter int TABLE_DEPTH          = 16,
	parameter int FILTER_FRACTION_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bse_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bse_pkg::CFG_DATA_W-1:0]  cfg_data,
	bse_req_if.sink                         req,
	bse_rsp_if.source                       rsp
);
	import bse_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	bse_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	bse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bse_datapath #(
		.TABLE_DEPTH          (TABLE_DEPTH),
		.FILTER_FRACTION_BITS (FILTER_FRACTION_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.sts              (sts),
		.mode             (req.mode),
		.sample_mv        (req.sample_mv),
		.entry_index      (req.entry_index),
		.entry_voltage_mv (req.entry_voltage_mv),
		.entry_charge     (req.entry_charge),
		.filtered_mv      (rsp.filtered_mv),
		.usable_charge    (rsp.usable_charge),
		.sample_rejected  (rsp.sample_rejected)
	);
endmodule

// ===== rtl/bse_cfg.sv =====
// ----------------------------------------------------------------------------
// bse_cfg
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module bse_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             we,
	input  logic [bse_pkg::CFG_IDX_W-1:0]    index,
	input  logic [bse_pkg::CFG_DATA_W-1:0]   data,
	output bse_pkg::cfg_t                    cfg
);
	import bse_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_gain       <= 16'd32768;
			cfg_q.offset_mv        <= 11'sd0;
			cfg_q.min_valid_mv     <= 13'd2500;
			cfg_q.max_valid_mv     <= 13'd4500;
			cfg_q.avg_weight       <= 9'd26;
			cfg_q.table_size       <= 5'd2;
			cfg_q.floor_voltage_mv <= 13'd3300;
		end else if (we) begin
			case (cfg_idx_t'(index))
				CFG_SCALE_GAIN: cfg_q.scale_gain       <= data[GAIN_W-1:0];
				CFG_OFFSET:     cfg_q.offset_mv        <= $signed(data[OFFS_W-1:0]);
				CFG_MIN_VALID:  cfg_q.min_valid_mv     <= data[VOLT_W-1:0];
				CFG_MAX_VALID:  cfg_q.max_valid_mv     <= data[VOLT_W-1:0];
				CFG_EMA_ALPHA:  cfg_q.avg_weight       <= data[ALPHA_W-1:0];
				CFG_TABLE_SIZE: cfg_q.table_size       <= data[TSIZE_W-1:0];
				CFG_FLOOR_VOLT: cfg_q.floor_voltage_mv <= data[VOLT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== rtl/bse_datapath.sv =====
// ----------------------------------------------------------------------------
// bse_datapath
// Correction, filter, table memory, search, shared restoring divider, remap.
// ----------------------------------------------------------------------------
module bse_datapath #(
	parameter int TABLE_DEPTH          = 16,
	parameter int FILTER_FRACTION_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bse_pkg::cfg_t                  cfg,
	input  bse_pkg::dp_cmd_t               cmd,
	output bse_pkg::dp_sts_t               sts,
	input  logic [bse_pkg::MODE_W-1:0]     mode,
	input  logic [bse_pkg::SAMPLE_W-1:0]   sample_mv,
	input  logic [bse_pkg::IDX_W-1:0]      entry_index,
	input  logic [bse_pkg::VOLT_W-1:0]     entry_voltage_mv,
	input  logic [bse_pkg::CHG_W-1:0]      entry_charge,
	output logic [bse_pkg::VOLT_W-1:0]     filtered_mv,
	output logic [bse_pkg::CHG_W-1:0]      usable_charge,
	output logic                           sample_rejected
);
	import bse_pkg::*;

	localparam int F   = FILTER_FRACTION_BITS;
	localparam int AW  = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IXW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
	localparam int FW  = VOLT_W + F;
	localparam int DW  = (FW > CHG_W) ? FW : CHG_W;
	localparam int PW  = DW + QUO_W;
	localparam int GPW = SAMPLE_W + GAIN_W;

	// Captured item.
	logic [MODE_W-1:0]   mode_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [IDX_W-1:0]    index_q;
	logic [VOLT_W-1:0]   ev_q;
	logic [CHG_W-1:0]    ec_q;

	// Table memory, one read port with registered data.
	logic [VOLT_W-1:0] tv_mem [TABLE_DEPTH];
	logic [CHG_W-1:0]  tc_mem [TABLE_DEPTH];
	logic [VOLT_W-1:0] rdv_q;
	logic [CHG_W-1:0]  rdc_q;
	logic [AW-1:0]     rd_addr;
	logic [IXW-1:0]    idx_ext;
	logic              wr_en;

	// Filter and sample state.
	logic [FW-1:0]     filt_q;
	logic [CHG_W-1:0]  floor_q;
	logic [GPW-1:0]    gprod_q;
	logic              ok_q;
	logic [FW-1:0]     x_q;

	// Lookup state.
	logic [FW-1:0]     v_q;
	logic [AW-1:0]     lo_q, hi_q, mid, last_addr;
	logic [VOLT_W-1:0] vlo_q, vhi_q;
	logic [CHG_W-1:0]  clo_q, chi_q, lkres_q;
	logic              up_q, den_zero_q;

	// Divider.
	logic [PW-1:0]     prod_q;
	logic [DW-1:0]     den_q, r_q;
	logic [QUO_W-1:0]  nq_q;
	logic [DW:0]       dv_t;
	logic              dv_ge;

	// Remap.
	logic [CHG_W-1:0]  anum_q, aden_q;
	logic              rm_zero_q, rm_sat_q;

	// Results.
	logic [VOLT_W-1:0] res_filt_q;
	logic [CHG_W-1:0]  res_usable_q;
	logic              res_rej_q;

	// Combinational helpers.
	logic [GPW-1:0]          rnd_sum;
	logic signed [15:0]      corr;
	logic                    ok_c;
	logic [ALPHA_W-1:0]      alpha_sat;
	logic [FW+ALPHA_W-1:0]   ema_a_prod, ema_b_prod;
	logic [FW+ALPHA_W:0]     ema_sum;
	logic [FW-1:0]           rdv_sh, vlo_sh, ip_diff, ip_den;
	logic [CHG_W-1:0]        ip_mag;
	logic [FW+CHG_W-1:0]     ip_prod;
	logic [AW:0]             lohi_sum, span;
	logic signed [CHG_W:0]   rm_num, rm_den;
	logic [CHG_W-1:0]        rm_anum, rm_aden;
	logic [2*CHG_W-1:0]      rm_prod;

	always_comb begin
		if (cfg.table_size < TSIZE_W'(2))
			last_addr = AW'(1);
		else if (int'(cfg.table_size) >= TABLE_DEPTH)
			last_addr = AW'(TABLE_DEPTH - 1);
		else
			last_addr = AW'(cfg.table_size - TSIZE_W'(1));
	end

	assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = lohi_sum[AW:1];
	assign span     = {1'b0, hi_q} - {1'b0, lo_q};

	always_comb begin
		case (cmd.op)
			OP_LK_INIT_FLOOR, OP_LK_INIT_FILT: rd_addr = '0;
			OP_LK_FIRST:                       rd_addr = last_addr;
			default:                           rd_addr = mid;
		endcase
	end

	assign idx_ext = IXW'(index_q);
	assign wr_en   = (cmd.op == OP_LOAD) && (mode_q == MODE_LOAD) &&
		(idx_ext < IXW'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tv_mem[idx_ext[AW-1:0]] <= ev_q;
			tc_mem[idx_ext[AW-1:0]] <= ec_q;
		end
		rdv_q <= tv_mem[rd_addr];
		rdc_q <= tc_mem[rd_addr];
	end

	// Sample correction.
	assign rnd_sum = gprod_q + GPW'(1 << (GAIN_FRAC - 1));
	assign corr    = $signed({2'b00, rnd_sum[GPW-1:GAIN_FRAC]}) + 16'(cfg.offset_mv);
	assign ok_c    = (corr >= $signed({3'b000, cfg.min_valid_mv})) &&
		(corr <= $signed({3'b000, cfg.max_valid_mv}));

	// Moving average.
	assign alpha_sat  = (cfg.avg_weight > ALPHA_ONE) ? ALPHA_ONE : cfg.avg_weight;
	assign ema_b_prod = (ALPHA_ONE - alpha_sat) * filt_q;
	assign ema_sum    = (FW+ALPHA_W+1)'(prod_q) + (FW+ALPHA_W+1)'(ema_b_prod) +
		(FW+ALPHA_W+1)'(128);
	assign ema_a_prod = alpha_sat * x_q;

	// Search and interpolation.
	assign rdv_sh  = FW'(rdv_q) << F;
	assign vlo_sh  = FW'(vlo_q) << F;
	assign ip_diff = v_q - vlo_sh;
	assign ip_den  = FW'(vhi_q - vlo_q) << F;
	assign ip_mag  = (chi_q >= clo_q) ? (chi_q - clo_q) : (clo_q - chi_q);
	assign ip_prod = ip_diff * ip_mag;

	// Restoring divider step: one quotient bit per cycle.
	assign dv_t  = {r_q, nq_q[QUO_W-1]};
	assign dv_ge = dv_t >= {1'b0, den_q};

	// Remap operands; a quotient that would come out negative or zero is zero.
	assign rm_num  = $signed({1'b0, lkres_q}) - $signed({1'b0, floor_q});
	assign rm_den  = $signed({1'b0, FULL_CHARGE}) - $signed({1'b0, floor_q});
	assign rm_anum = rm_num[CHG_W] ? CHG_W'(-rm_num) : rm_num[CHG_W-1:0];
	assign rm_aden = rm_den[CHG_W] ? CHG_W'(-rm_den) : rm_den[CHG_W-1:0];
	assign rm_prod = anum_q * FULL_CHARGE;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode;
			sample_q <= sample_mv;
			index_q  <= entry_index;
			ev_q     <= entry_voltage_mv;
			ec_q     <= entry_charge;
		end
		case (cmd.op)
			OP_MUL_GAIN: gprod_q <= sample_q * cfg.scale_gain;
			OP_CORRECT: begin
				ok_q <= ok_c;
				x_q  <= ok_c ? (FW'(corr[VOLT_W-1:0]) << F) : '0;
			end
			OP_LK_INIT_FLOOR, OP_LK_INIT_FILT: begin
				v_q  <= (cmd.op == OP_LK_INIT_FLOOR) ? (FW'(cfg.floor_voltage_mv) << F)
					: filt_q;
				lo_q <= '0;
				hi_q <= last_addr;
			end
			OP_LK_FIRST: begin
				vlo_q   <= rdv_q;
				clo_q   <= rdc_q;
				lkres_q <= rdc_q;
			end
			OP_LK_LAST: begin
				vhi_q   <= rdv_q;
				chi_q   <= rdc_q;
				lkres_q <= rdc_q;
			end
			OP_LK_MIDCHK: begin
				if (rdv_sh <= v_q) begin
					lo_q  <= mid;
					vlo_q <= rdv_q;
					clo_q <= rdc_q;
				end else begin
					hi_q  <= mid;
					vhi_q <= rdv_q;
					chi_q <= rdc_q;
				end
			end
			OP_IP_MUL: begin
				prod_q     <= PW'(ip_prod);
				den_q      <= DW'(ip_den);
				den_zero_q <= (ip_den == '0);
				up_q       <= (chi_q >= clo_q);
			end
			OP_DIV_LOAD: begin
				r_q  <= prod_q[PW-1:QUO_W];
				nq_q <= prod_q[QUO_W-1:0];
			end
			OP_DIV_STEP: begin
				r_q  <= dv_ge ? DW'(dv_t - {1'b0, den_q}) : dv_t[DW-1:0];
				nq_q <= {nq_q[QUO_W-2:0], dv_ge};
			end
			OP_IP_FIN: begin
				if (den_zero_q)
					lkres_q <= clo_q;
				else if (up_q)
					lkres_q <= clo_q + nq_q;
				else
					lkres_q <= clo_q - nq_q;
			end
			OP_EMA_MUL: prod_q <= PW'(ema_a_prod);
			OP_RM_SETUP: begin
				anum_q    <= rm_anum;
				aden_q    <= rm_aden;
				rm_zero_q <= (rm_num == '0) || (rm_den == '0) || (rm_num[CHG_W] != rm_den[CHG_W]);
				rm_sat_q  <= (rm_anum >= rm_aden);
			end
			OP_RM_MUL: begin
				prod_q <= PW'(rm_prod);
				den_q  <= DW'(aden_q);
			end
			OP_RM_FIN: begin
				res_filt_q <= filt_q[FW-1 -: VOLT_W];
				res_rej_q  <= !ok_q;
				if (rm_zero_q)
					res_usable_q <= '0;
				else if (rm_sat_q)
					res_usable_q <= FULL_CHARGE;
				else
					res_usable_q <= nq_q;
			end
			OP_LOAD: begin
				res_filt_q   <= filt_q[FW-1 -: VOLT_W];
				res_usable_q <= '0;
				res_rej_q    <= 1'b0;
			end
			default: ;
		endcase
	end

	// Architectural state with a defined reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q  <= '0;
			floor_q <= '0;
		end else begin
			case (cmd.op)
				OP_SEED: begin
					floor_q <= lkres_q;
					if (ok_q)
						filt_q <= x_q;
				end
				OP_EMA_ADD: begin
					if (ok_q)
						filt_q <= ema_sum[FW+7:8];
				end
				default: ;
			endcase
		end
	end

	assign sts.mode     = mode_q;
	assign sts.le_first = (v_q <= rdv_sh);
	assign sts.ge_last  = (v_q >= rdv_sh);
	assign sts.span_gt1 = (span > (AW+1)'(1));

	assign filtered_mv     = res_filt_q;
	assign usable_charge   = res_usable_q;
	assign sample_rejected = res_rej_q;
endmodule

// ===== rtl/bse_ctrl.sv =====
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer that steps the datapath through one item at a time.
// ----------------------------------------------------------------------------
`include "battery_soc_estimator_unit_macros.svh"

module bse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output bse_pkg::dp_cmd_t  cmd,
	input  bse_pkg::dp_sts_t  sts
);
	import bse_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	typedef enum logic [4:0] {
		S_IDLE, S_MUL_GAIN, S_CORRECT, S_LOAD, S_LK_INIT, S_LK_FIRST, S_LK_LAST,
		S_LK_MID, S_LK_MIDCHK, S_IP_MUL, S_DIV_LOAD, S_DIV_STEP, S_IP_FIN,
		S_SEED, S_EMA_MUL, S_EMA_ADD, S_RM_SETUP, S_RM_MUL, S_RM_FIN, S_DONE
	} state_t;

	state_t           state_q;
	logic             lk_floor_q;
	logic             div_rm_q;
	logic [CNT_W-1:0] cnt_q;
	state_t           after_lk;

	// Where a finished lookup goes: the floor lookup feeds the seed step.
	assign after_lk = lk_floor_q ? S_SEED : S_RM_SETUP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lk_floor_q <= 1'b0;
			div_rm_q   <= 1'b0;
			cnt_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MUL_GAIN;
				S_MUL_GAIN: begin
					if (sts.mode == MODE_SEED || sts.mode == MODE_UPDATE)
						state_q <= S_CORRECT;
					else
						state_q <= S_LOAD;
				end
				S_CORRECT: begin
					lk_floor_q <= (sts.mode == MODE_SEED);
					state_q    <= (sts.mode == MODE_SEED) ? S_LK_INIT : S_EMA_MUL;
				end
				S_LOAD:     state_q <= S_DONE;
				S_LK_INIT:  state_q <= S_LK_FIRST;
				S_LK_FIRST: state_q <= sts.le_first ? after_lk : S_LK_LAST;
				S_LK_LAST:  state_q <= sts.ge_last ? after_lk : S_LK_MID;
				S_LK_MID:   state_q <= sts.span_gt1 ? S_LK_MIDCHK : S_IP_MUL;
				S_LK_MIDCHK: state_q <= S_LK_MID;
				S_IP_MUL: begin
					div_rm_q <= 1'b0;
					state_q  <= S_DIV_LOAD;
				end
				S_DIV_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_DIV_STEP;
				end
				S_DIV_STEP: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(QUO_W - 1))
						state_q <= div_rm_q ? S_RM_FIN : S_IP_FIN;
				end
				S_IP_FIN: state_q <= after_lk;
				S_SEED: begin
					lk_floor_q <= 1'b0;
					state_q    <= S_LK_INIT;
				end
				S_EMA_MUL:  state_q <= S_EMA_ADD;
				S_EMA_ADD:  state_q <= S_LK_INIT;
				S_RM_SETUP: state_q <= S_RM_MUL;
				S_RM_MUL: begin
					div_rm_q <= 1'b1;
					state_q  <= S_DIV_LOAD;
				end
				S_RM_FIN: state_q <= S_DONE;
				S_DONE:   if (out_ready) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.capture = in_valid && in_ready;
		case (state_q)
			S_MUL_GAIN:  cmd.op = OP_MUL_GAIN;
			S_CORRECT:   cmd.op = OP_CORRECT;
			S_LOAD:      cmd.op = OP_LOAD;
			S_LK_INIT:   cmd.op = lk_floor_q ? OP_LK_INIT_FLOOR : OP_LK_INIT_FILT;
			S_LK_FIRST:  cmd.op = OP_LK_FIRST;
			S_LK_LAST:   cmd.op = OP_LK_LAST;
			S_LK_MID:    cmd.op = OP_LK_MID;
			S_LK_MIDCHK: cmd.op = OP_LK_MIDCHK;
			S_IP_MUL:    cmd.op = OP_IP_MUL;
			S_DIV_LOAD:  cmd.op = OP_DIV_LOAD;
			S_DIV_STEP:  cmd.op = OP_DIV_STEP;
			S_IP_FIN:    cmd.op = OP_IP_FIN;
			S_SEED:      cmd.op = OP_SEED;
			S_EMA_MUL:   cmd.op = OP_EMA_MUL;
			S_EMA_ADD:   cmd.op = OP_EMA_ADD;
			S_RM_SETUP:  cmd.op = OP_RM_SETUP;
			S_RM_MUL:    cmd.op = OP_RM_MUL;
			S_RM_FIN:    cmd.op = OP_RM_FIN;
			default:     cmd.op = OP_IDLE;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	`BSE_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_q != S_IDLE)
	`BSE_ASSERT_NEXT(a_transfer_returns, out_valid && out_ready, in_ready)
	`BSE_ASSERT_IMP(a_div_count, state_q == S_DIV_STEP, cnt_q <= CNT_W'(QUO_W - 1))
	`BSE_ASSERT_NEXT(a_div_ends, state_q == S_DIV_STEP && cnt_q == CNT_W'(QUO_W - 1),
		state_q == S_RM_FIN || state_q == S_IP_FIN)
endmodule
